[rtl/iesq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iesq_pkg
// Types, codes and constants shared by the interrupt entry sequencer.
// ----------------------------------------------------------------------------
package iesq_pkg;

    localparam int unsigned MAX_RES   = 4;
    localparam int unsigned RES_CNT_W = 3;

    // input opcodes
    localparam logic [1:0] OP_HW_INT    = 2'd0;
    localparam logic [1:0] OP_SW_INT    = 2'd1;
    localparam logic [1:0] OP_READ_RESP = 2'd2;

    // register indexes
    localparam logic REG_IDT_BASE = 1'b0;
    localparam logic REG_GDT_BASE = 1'b1;

    localparam logic [3:0]  GATE_TYPE_INT = 4'hE;
    localparam logic [15:0] LIMIT_FLAT    = 16'hFFFF;
    localparam logic [31:0] SW_PC_STEP    = 32'd2;
    localparam logic [31:0] WORD_BYTES    = 32'd4;
    localparam logic [31:0] PUSH_1        = 32'd4;
    localparam logic [31:0] PUSH_2        = 32'd8;
    localparam logic [31:0] PUSH_3        = 32'd12;
    localparam int unsigned IF_BIT        = 9;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_FAULT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_GATE_LO = 3'd1,
        PH_GATE_HI = 3'd2,
        PH_SEG_LO  = 3'd3,
        PH_SEG_HI  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  vector;
        logic [31:0] flags_in;
        logic [15:0] code_selector_in;
        logic [31:0] pc_in;
        logic [31:0] stack_ptr_in;
        logic [31:0] read_data;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] mem_addr;
        logic [31:0] write_data;
        logic [31:0] new_pc;
        logic [31:0] new_stack_ptr;
        logic [31:0] new_flags;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]      cnt;
        t_result [MAX_RES-1:0]     res;
    } t_res_set;

    localparam t_result RESULT_ZERO = '{
        kind: KIND_WRITE, mem_addr: '0, write_data: '0, new_pc: '0,
        new_stack_ptr: '0, new_flags: '0, last: 1'b0
    };

endpackage

[rtl/iesq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iesq_core
// Entry phase machine: turns one item into its set of results and updates
// the saved entry state.
// ----------------------------------------------------------------------------
module iesq_core
    import iesq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  t_item       i_item,
    input  logic [31:0] i_idt_base,
    input  logic [31:0] i_gdt_base,
    output t_res_set    o_set
);

    t_phase      r_phase,       n_phase;
    logic [31:0] r_saved_flags, n_saved_flags;
    logic [31:0] r_saved_sp,    n_saved_sp;
    logic [31:0] r_gate_lo,     n_gate_lo;
    logic [31:0] r_handler_off, n_handler_off;
    logic [31:0] r_seg_lo,      n_seg_lo;
    logic [31:0] r_next_addr,   n_next_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_saved_flags <= '0;
            r_saved_sp    <= '0;
            r_gate_lo     <= '0;
            r_handler_off <= '0;
            r_seg_lo      <= '0;
            r_next_addr   <= '0;
        end else begin
            r_phase       <= n_phase;
            r_saved_flags <= n_saved_flags;
            r_saved_sp    <= n_saved_sp;
            r_gate_lo     <= n_gate_lo;
            r_handler_off <= n_handler_off;
            r_seg_lo      <= n_seg_lo;
            r_next_addr   <= n_next_addr;
        end
    end

    always_comb begin
        logic [31:0] pc;
        logic [31:0] gate_addr;
        logic [31:0] gdt_addr;
        logic [31:0] flags;
        logic [31:0] seg_base;
        logic [12:0] desc_idx;
        logic        seg_ok;

        n_phase       = r_phase;
        n_saved_flags = r_saved_flags;
        n_saved_sp    = r_saved_sp;
        n_gate_lo     = r_gate_lo;
        n_handler_off = r_handler_off;
        n_seg_lo      = r_seg_lo;
        n_next_addr   = r_next_addr;
        o_set.cnt     = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            o_set.res[k] = RESULT_ZERO;
        end

        pc        = i_item.pc_in + ((i_item.opcode == OP_SW_INT) ? SW_PC_STEP : 32'd0);
        gate_addr = i_idt_base + {21'd0, i_item.vector, 3'd0};
        flags     = r_saved_flags;
        if (i_item.read_data[11:8] == GATE_TYPE_INT) begin
            flags[IF_BIT] = 1'b0;
        end
        desc_idx  = r_gate_lo[31:19];
        gdt_addr  = i_gdt_base + {16'd0, desc_idx, 3'd0};
        seg_base  = {i_item.read_data[31:24], i_item.read_data[7:0], r_seg_lo[31:16]};
        seg_ok    = (r_seg_lo[31:16] == 16'd0) && (r_seg_lo[15:0] == LIMIT_FLAT)
                    && i_item.read_data[23];

        if (i_take) begin
            case (i_item.opcode)
                OP_HW_INT, OP_SW_INT: begin
                    n_saved_flags = i_item.flags_in;
                    n_saved_sp    = i_item.stack_ptr_in - PUSH_3;
                    n_next_addr   = gate_addr;
                    n_phase       = PH_GATE_LO;
                    o_set.cnt     = RES_CNT_W'(MAX_RES);
                    o_set.res[0].mem_addr   = i_item.stack_ptr_in - PUSH_1;
                    o_set.res[0].write_data = i_item.flags_in;
                    o_set.res[1].mem_addr   = i_item.stack_ptr_in - PUSH_2;
                    o_set.res[1].write_data = {16'd0, i_item.code_selector_in};
                    o_set.res[2].mem_addr   = i_item.stack_ptr_in - PUSH_3;
                    o_set.res[2].write_data = pc;
                    o_set.res[3].kind       = KIND_READ;
                    o_set.res[3].mem_addr   = gate_addr;
                    o_set.res[3].last       = 1'b1;
                end
                OP_READ_RESP: begin
                    case (r_phase)
                        PH_GATE_LO: begin
                            n_gate_lo = i_item.read_data;
                            n_phase   = PH_GATE_HI;
                            o_set.cnt = RES_CNT_W'(1);
                            o_set.res[0].kind     = KIND_READ;
                            o_set.res[0].mem_addr = r_next_addr + WORD_BYTES;
                            o_set.res[0].last     = 1'b1;
                        end
                        PH_GATE_HI: begin
                            n_saved_flags = flags;
                            n_handler_off = {i_item.read_data[31:16], r_gate_lo[15:0]};
                            o_set.cnt     = RES_CNT_W'(1);
                            o_set.res[0].last = 1'b1;
                            if (desc_idx == 13'd0) begin
                                n_phase = PH_IDLE;
                                o_set.res[0].kind          = KIND_FAULT;
                                o_set.res[0].new_stack_ptr = r_saved_sp;
                                o_set.res[0].new_flags     = flags;
                            end else begin
                                n_phase     = PH_SEG_LO;
                                n_next_addr = gdt_addr;
                                o_set.res[0].kind     = KIND_READ;
                                o_set.res[0].mem_addr = gdt_addr;
                            end
                        end
                        PH_SEG_LO: begin
                            n_seg_lo  = i_item.read_data;
                            n_phase   = PH_SEG_HI;
                            o_set.cnt = RES_CNT_W'(1);
                            o_set.res[0].kind     = KIND_READ;
                            o_set.res[0].mem_addr = r_next_addr + WORD_BYTES;
                            o_set.res[0].last     = 1'b1;
                        end
                        PH_SEG_HI: begin
                            n_phase   = PH_IDLE;
                            o_set.cnt = RES_CNT_W'(1);
                            o_set.res[0].last          = 1'b1;
                            o_set.res[0].new_stack_ptr = r_saved_sp;
                            o_set.res[0].new_flags     = r_saved_flags;
                            if (seg_ok) begin
                                o_set.res[0].kind   = KIND_DONE;
                                o_set.res[0].new_pc = seg_base + r_handler_off;
                            end else begin
                                o_set.res[0].kind   = KIND_FAULT;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

endmodule

[rtl/iesq_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iesq_obuf
// Result buffer: holds the results of one item and sends them out one beat
// at a time.
// ----------------------------------------------------------------------------
module iesq_obuf
    import iesq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_res_set     i_set,
    output logic         o_free,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output t_result      o_res
);

    t_result                r_res [MAX_RES];
    logic [RES_CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]             r_idx, n_idx;
    logic                   pop;

    always_comb begin
        pop    = (r_cnt != '0) && i_m_axis_tready;
        o_free = (r_cnt == '0) || ((r_cnt == RES_CNT_W'(1)) && i_m_axis_tready);
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        if (i_load) begin
            n_cnt = i_set.cnt;
            n_idx = '0;
        end else if (pop) begin
            n_cnt = r_cnt - RES_CNT_W'(1);
            n_idx = r_idx + 2'd1;
        end
        o_m_axis_tvalid = (r_cnt != '0);
        o_res           = r_res[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_res[k] <= i_set.res[k];
            end
        end
    end

endmodule

[rtl/interrupt_entry_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_entry_sequencer
// Protected-mode interrupt entry: stack pushes, gate and descriptor reads,
// descriptor check and handler entry.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         tdata item fields, tuser opcode
//  m_axis    out        tvalid / tready         tdata result fields, tuser kind,
//                                               tlast
//  cfg       in         valid / ready           index, data
//
//  A trigger gives four result beats, a read response one beat; the single
//  beat per cycle of the result buffer, while m_axis tready is high, sets
//  the pace. The first beat follows in the cycle after the item is taken.
//  Reset is synchronous and active low; it clears the phase, the saved
//  state and both base registers. A stall on m_axis holds the result buffer
//  and, once the input register is full, drops s_axis tready.
// ----------------------------------------------------------------------------
module interrupt_entry_sequencer
    import iesq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // vector, flags_in, code_selector_in, pc_in, stack_ptr_in, read_data
    input  logic [151:0] i_s_axis_tdata,
    // opcode
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // mem_addr, write_data, new_pc, new_stack_ptr, new_flags
    output logic [159:0] o_m_axis_tdata,
    // kind
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    logic [31:0] r_idt_base;
    logic [31:0] r_gdt_base;
    logic        r_in_valid, n_in_valid;
    t_item       r_in;
    logic        take;
    logic        obuf_free;
    t_res_set    res_set;
    t_result     out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idt_base <= '0;
            r_gdt_base <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IDT_BASE: r_idt_base <= i_cfg_data;
                REG_GDT_BASE: r_gdt_base <= i_cfg_data;
                default:      r_idt_base <= r_idt_base;
            endcase
        end
    end

    always_comb begin
        take            = r_in_valid && obuf_free;
        o_s_axis_tready = !r_in_valid || take;
        n_in_valid      = r_in_valid;
        if (o_s_axis_tready) begin
            n_in_valid = i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.opcode           <= i_s_axis_tuser;
            r_in.vector           <= i_s_axis_tdata[7:0];
            r_in.flags_in         <= i_s_axis_tdata[39:8];
            r_in.code_selector_in <= i_s_axis_tdata[55:40];
            r_in.pc_in            <= i_s_axis_tdata[87:56];
            r_in.stack_ptr_in     <= i_s_axis_tdata[119:88];
            r_in.read_data        <= i_s_axis_tdata[151:120];
        end
    end

    iesq_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (r_in),
        .i_idt_base (r_idt_base),
        .i_gdt_base (r_gdt_base),
        .o_set      (res_set)
    );

    iesq_obuf u_obuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (take),
        .i_set           (res_set),
        .o_free          (obuf_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_res           (out_res)
    );

    assign o_m_axis_tdata = {out_res.new_flags, out_res.new_stack_ptr, out_res.new_pc,
                             out_res.write_data, out_res.mem_addr};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.last;

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_DONE || o_m_axis_tuser == KIND_FAULT)
        |-> o_m_axis_tlast)
        else $error("done or fault beat without tlast");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_trigger_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (r_in.opcode == OP_HW_INT || r_in.opcode == OP_SW_INT)
        |=> o_m_axis_tvalid && (o_m_axis_tuser == KIND_WRITE) && !o_m_axis_tlast)
        else $error("trigger did not start with a stack write");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !obuf_free |=> r_in_valid && $stable(r_in))
        else $error("input item lost while result buffer busy");
`endif

endmodule
